// ===== src/bbl_pkg.sv =====
// Shared types, constants and a lookup function for the 3x3 box blur stream core.
package bbl_pkg;

   localparam int MAX_ROW_WIDTH_DEF = 1024;
   localparam int QUEUE_DEPTH       = 4;
   localparam int RECIP_SHIFT       = 17;
   localparam int SUM_W             = 12;
   localparam int DIVD_W            = 13;
   localparam int RECIP_W           = 17;
   localparam int PROD_W            = DIVD_W + RECIP_W;

   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [15:0] FRAME_HEIGHT_RST = 16'd768;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [15:0] out_row;
      logic [9:0]  out_col;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } chsum_type;

   // One output pixel still to be divided
   typedef struct packed {
      chsum_type   sum;
      logic [3:0]  cnt;
      logic [15:0] row;
      logic [9:0]  col;
      logic        last;
   } job_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_READ,
      FRONT_ISSUE
   } front_state_type;

   // ceil(2^17 / (2*n)) for every neighbour count that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/bbl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bbl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bbl_fifo.sv =====
// Small flop-based first-in first-out queue.
module bbl_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 4,
   parameter int  PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  T            wr_data,
   output logic        full,
   input  logic        pop,
   output T            rd_data,
   output logic        empty,
   output logic [PW:0] count
);

   T            mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (32'(count_ff) == DEPTH);
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/bbl_front.sv =====
// Front end: frame position, row stores, column sums and output job issue.
module bbl_front #(
   parameter int MAX_ROW_WIDTH = bbl_pkg::MAX_ROW_WIDTH_DEF,
   parameter int AW            = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  bbl_pkg::req_type  req_data,
   output logic              req_full,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_data,
   output logic              job_push,
   output bbl_pkg::job_type  job_data,
   input  logic              job_full
);

   import bbl_pkg::*;

   front_state_type state_ff, state_in;
   logic [10:0]     fw_ff, fw_in;
   logic [15:0]     fh_ff, fh_in;
   logic [AW-1:0]   x_ff, x_in;
   logic [15:0]     y_ff, y_in;
   req_type         px_ff, px_in;
   chsum_type       s3_ff [3];
   chsum_type       s3_in [3];
   chsum_type       s2_ff [3];
   chsum_type       s2_in [3];
   job_type         slot_ff [4];
   job_type         slot_in [4];
   logic [3:0]      slot_vld_ff, slot_vld_in;
   logic [1:0]      slot_idx_ff, slot_idx_in;

   logic [AW:0]     w_eff;
   logic [15:0]     h_eff;
   logic            last_col, last_row, rd_en, wr_en, cfg_wr;
   logic [23:0]     rd_newer, rd_older;
   req_type         above, above2;
   logic [1:0]      rows_top, rows_bot, cols_a, cols_b;
   logic [AW-1:0]   xm1;
   logic [9:0]      col_x, col_xm1;
   logic [3:0]      emit;

   function automatic chsum_type add3(input req_type a, input req_type b, input req_type c);
      chsum_type s;
      s.red   = SUM_W'(a.pixel_red)   + SUM_W'(b.pixel_red)   + SUM_W'(c.pixel_red);
      s.green = SUM_W'(a.pixel_green) + SUM_W'(b.pixel_green) + SUM_W'(c.pixel_green);
      s.blue  = SUM_W'(a.pixel_blue)  + SUM_W'(b.pixel_blue)  + SUM_W'(c.pixel_blue);
      return s;
   endfunction

   function automatic chsum_type win(input chsum_type a, input chsum_type b,
                                     input chsum_type c, input logic skip_a);
      chsum_type s;
      s.red   = (skip_a ? '0 : a.red)   + b.red   + c.red;
      s.green = (skip_a ? '0 : a.green) + b.green + c.green;
      s.blue  = (skip_a ? '0 : a.blue)  + b.blue  + c.blue;
      return s;
   endfunction

   bbl_ram #(.WIDTH(24), .DEPTH(MAX_ROW_WIDTH), .AW(AW)) u_newer (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(x_ff),
      .wr_data(px_ff),
      .rd_en  (rd_en),
      .rd_addr(x_ff),
      .rd_data(rd_newer)
   );

   bbl_ram #(.WIDTH(24), .DEPTH(MAX_ROW_WIDTH), .AW(AW)) u_older (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(x_ff),
      .wr_data(rd_newer),
      .rd_en  (rd_en),
      .rd_addr(x_ff),
      .rd_data(rd_older)
   );

   always_comb begin
      if (fw_ff == '0) begin
         w_eff = (AW+1)'(1);
      end else if (32'(fw_ff) > MAX_ROW_WIDTH) begin
         w_eff = (AW+1)'(MAX_ROW_WIDTH);
      end else begin
         w_eff = (AW+1)'(fw_ff);
      end
      h_eff = (fh_ff == '0) ? 16'd1 : fh_ff;
   end

   assign last_col  = ({1'b0, x_ff} == (AW+1)'(w_eff - 1'b1));
   assign last_row  = (y_ff == h_eff - 1'b1);
   assign req_full  = (state_ff != FRONT_IDLE);
   // a request in the same cycle wins over a register write
   assign csr_ready = (state_ff == FRONT_IDLE) && !req_push;
   assign rd_en     = req_push && (state_ff == FRONT_IDLE);
   assign wr_en     = (state_ff == FRONT_READ);
   assign cfg_wr    = csr_valid && csr_ready;
   assign above     = (y_ff != '0) ? req_type'(rd_newer) : '0;
   assign above2    = (y_ff > 16'd1) ? req_type'(rd_older) : '0;
   assign rows_top  = (y_ff > 16'd1) ? 2'd3 : 2'd2;
   assign rows_bot  = (y_ff != '0) ? 2'd2 : 2'd1;
   assign cols_a    = (32'(x_ff) >= 2) ? 2'd3 : 2'd2;
   assign cols_b    = (x_ff != '0) ? 2'd2 : 2'd1;
   assign xm1       = x_ff - 1'b1;
   assign col_x     = 10'(32'(x_ff));
   assign col_xm1   = 10'(32'(xm1));
   assign emit[0]   = (y_ff != '0) && (x_ff != '0);
   assign emit[1]   = (y_ff != '0) && last_col;
   assign emit[2]   = last_row && (x_ff != '0);
   assign emit[3]   = last_row && last_col;

   always_comb begin
      state_in    = state_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      px_in       = px_ff;
      s3_in       = s3_ff;
      s2_in       = s2_ff;
      slot_in     = slot_ff;
      slot_vld_in = slot_vld_ff;
      slot_idx_in = slot_idx_ff;
      job_push    = 1'b0;
      job_data    = slot_ff[slot_idx_ff];

      case (state_ff)
         FRONT_IDLE: begin
            if (req_push) begin
               px_in    = req_data;
               state_in = FRONT_READ;
            end else if (cfg_wr) begin
               // restart the frame on any register write
               if (csr_index == CSR_FRAME_WIDTH) begin
                  fw_in = csr_data[10:0];
               end else begin
                  fh_in = csr_data;
               end
               x_in = '0;
               y_in = '0;
               for (int i = 0; i < 3; i++) begin
                  s3_in[i] = '0;
                  s2_in[i] = '0;
               end
            end
         end
         FRONT_READ: begin
            // shift the column window, dropping it at the start of a row
            s3_in[0] = (x_ff == '0) ? '0 : s3_ff[1];
            s3_in[1] = (x_ff == '0) ? '0 : s3_ff[2];
            s2_in[0] = (x_ff == '0) ? '0 : s2_ff[1];
            s2_in[1] = (x_ff == '0) ? '0 : s2_ff[2];
            s3_in[2] = add3(px_ff, above, above2);
            s2_in[2] = add3(px_ff, above, '0);

            slot_in[0].sum = win(s3_in[0], s3_in[1], s3_in[2], 1'b0);
            slot_in[0].cnt = 4'(rows_top) * 4'(cols_a);
            slot_in[0].row = y_ff - 1'b1;
            slot_in[0].col = col_xm1;
            slot_in[1].sum = win(s3_in[0], s3_in[1], s3_in[2], 1'b1);
            slot_in[1].cnt = 4'(rows_top) * 4'(cols_b);
            slot_in[1].row = y_ff - 1'b1;
            slot_in[1].col = col_x;
            slot_in[2].sum = win(s2_in[0], s2_in[1], s2_in[2], 1'b0);
            slot_in[2].cnt = 4'(rows_bot) * 4'(cols_a);
            slot_in[2].row = y_ff;
            slot_in[2].col = col_xm1;
            slot_in[3].sum = win(s2_in[0], s2_in[1], s2_in[2], 1'b1);
            slot_in[3].cnt = 4'(rows_bot) * 4'(cols_b);
            slot_in[3].row = y_ff;
            slot_in[3].col = col_x;
            slot_in[0].last = !emit[1] && !emit[2] && !emit[3];
            slot_in[1].last = !emit[2] && !emit[3];
            slot_in[2].last = !emit[3];
            slot_in[3].last = 1'b1;
            slot_vld_in     = emit;
            slot_idx_in     = '0;

            if (last_col) begin
               x_in = '0;
               y_in = last_row ? '0 : y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
            state_in = FRONT_ISSUE;
         end
         FRONT_ISSUE: begin
            job_push = slot_vld_ff[slot_idx_ff];
            if (!slot_vld_ff[slot_idx_ff] || !job_full) begin
               slot_idx_in = slot_idx_ff + 1'b1;
               if (slot_idx_ff == 2'd3) begin
                  state_in = FRONT_IDLE;
               end
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FRONT_IDLE;
         fw_ff       <= FRAME_WIDTH_RST;
         fh_ff       <= FRAME_HEIGHT_RST;
         x_ff        <= '0;
         y_ff        <= '0;
         slot_vld_ff <= '0;
         slot_idx_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            s3_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         slot_vld_ff <= slot_vld_in;
         slot_idx_ff <= slot_idx_in;
         s3_ff       <= s3_in;
         s2_ff       <= s2_in;
      end
      px_ff   <= px_in;
      slot_ff <= slot_in;
   end

endmodule

// ===== src/bbl_back.sv =====
// Back end: rounded mean by reciprocal multiply, then the result queue.
module bbl_back (
   input  logic              clock,
   input  logic              reset,
   input  bbl_pkg::job_type  job_data,
   input  logic              job_empty,
   output logic              job_pop,
   output bbl_pkg::rsp_type  rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   import bbl_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic              va_ff, va_in;
   logic [PROD_W-1:0] pr_ff, pg_ff, pb_ff;
   logic [15:0]       row_ff;
   logic [9:0]        col_ff;
   logic              last_ff;
   logic [RECIP_W-1:0] rcp;
   logic [PW:0]       out_count;
   logic              out_full;
   rsp_type           res;

   function automatic logic [DIVD_W-1:0] divd(input logic [SUM_W-1:0] s, input logic [3:0] n);
      return {s, 1'b0} + DIVD_W'(n);
   endfunction

   // hold back while the result queue could overflow
   assign job_pop = !job_empty && ((32'(out_count) + 32'(va_ff)) < QUEUE_DEPTH);
   assign va_in   = job_pop;
   assign rcp     = recip(job_data.cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
      end
      if (job_pop) begin
         pr_ff   <= PROD_W'(divd(job_data.sum.red, job_data.cnt)) * PROD_W'(rcp);
         pg_ff   <= PROD_W'(divd(job_data.sum.green, job_data.cnt)) * PROD_W'(rcp);
         pb_ff   <= PROD_W'(divd(job_data.sum.blue, job_data.cnt)) * PROD_W'(rcp);
         row_ff  <= job_data.row;
         col_ff  <= job_data.col;
         last_ff <= job_data.last;
      end
   end

   always_comb begin
      res.out_red     = pr_ff[RECIP_SHIFT +: 8];
      res.out_green   = pg_ff[RECIP_SHIFT +: 8];
      res.out_blue    = pb_ff[RECIP_SHIFT +: 8];
      res.out_row     = row_ff;
      res.out_col     = col_ff;
      res.last_of_run = last_ff;
   end

   bbl_fifo #(.T(rsp_type), .DEPTH(QUEUE_DEPTH), .PW(PW)) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (va_ff),
      .wr_data(res),
      .full   (out_full),
      .pop    (rsp_pop),
      .rd_data(rsp_data),
      .empty  (rsp_empty),
      .count  (out_count)
   );

   // credit check keeps the queue from overflowing when a result lands
   logic unused_full;
   assign unused_full = out_full;

endmodule

// ===== src/box_blur_3x3_stream_core.sv =====
// Top level of the 3x3 edge-normalised box blur over a raster RGB pixel stream.
//
//  channel  direction  handshake           payload
//  req_     in         req_push / req_full  bbl_pkg::req_type pixel
//  rsp_     out        rsp_pop / rsp_empty  bbl_pkg::rsp_type blurred pixel + position
//  csr_     in         csr_valid / csr_ready  index 0 width, 1 height
//
// Each pixel passes the front end in turn: accept with row store read, window
// update, then four job issue slots; a full job queue holds a slot until it has room.
// The back end divides one job a cycle by reciprocal multiply unless results back up.
// Reset is synchronous; row stores are not cleared and are used only once written.
// A full result queue stalls the back end, then the job queue, then req_full.
module box_blur_3x3_stream_core #(
   parameter int MAX_ROW_WIDTH = bbl_pkg::MAX_ROW_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  bbl_pkg::req_type  req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bbl_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);

   import bbl_pkg::*;

   localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic    job_push, job_full, job_empty, job_pop;
   job_type job_wr, job_rd;
   logic [PW:0] job_count;

   bbl_front #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH), .AW(AW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .job_push (job_push),
      .job_data (job_wr),
      .job_full (job_full)
   );

   bbl_fifo #(.T(job_type), .DEPTH(QUEUE_DEPTH), .PW(PW)) u_job_q (
      .clock  (clock),
      .reset  (reset),
      .push   (job_push),
      .wr_data(job_wr),
      .full   (job_full),
      .pop    (job_pop),
      .rd_data(job_rd),
      .empty  (job_empty),
      .count  (job_count)
   );

   bbl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_data (job_rd),
      .job_empty(job_empty),
      .job_pop  (job_pop),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop)
   );

   logic unused_count;
   assign unused_count = |job_count;

endmodule

// ===== src/bbl_checker.sv =====
// Port-level checks for the box blur core, bound to the top level.
module bbl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input bbl_pkg::req_type  req_data,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input bbl_pkg::rsp_type  rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_index,
   input logic [15:0]       csr_data
);

   // an accepted request keeps the input closed for the window update
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("input open right after an accepted request");

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input closed right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

endmodule

bind box_blur_3x3_stream_core bbl_checker u_bbl_checker (.*);

// ===== test/box_blur_3x3_stream_core_tb.sv =====
// Self-checking testbench for the 3x3 box blur stream core.
`timescale 1ns / 1ps

module box_blur_3x3_stream_core_tb;
   import bbl_pkg::*;

   localparam int ROW_DEPTH = MAX_ROW_WIDTH_DEF;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   box_blur_3x3_stream_core u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // blur predictor state
   logic [7:0]  above_row [ROW_DEPTH][3];
   logic [7:0]  older_row [ROW_DEPTH][3];
   int unsigned sum3 [3][3];
   int unsigned sum2 [3][3];
   int unsigned cur_row, cur_col;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;

   rsp_type     blurred_q [$];
   int          fail_count;
   bit          rx_hold;
   bit          rx_no_idle;
   bit          tx_no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void restart_frame();
      for (int p = 0; p < 3; p++)
         for (int c = 0; c < 3; c++) begin
            sum3[p][c] = 0;
            sum2[p][c] = 0;
         end
      cur_row = 0;
      cur_col = 0;
   endfunction

   function automatic rsp_type blur_pixel(bit use3, int first, int unsigned cnt,
                                          int unsigned row, int unsigned col);
      rsp_type r;
      int unsigned s [3];
      for (int c = 0; c < 3; c++) begin
         s[c] = 0;
         for (int p = first; p < 3; p++)
            s[c] += use3 ? sum3[p][c] : sum2[p][c];
         s[c] = (2 * s[c] + cnt) / (2 * cnt);
      end
      r.out_red     = s[0][7:0];
      r.out_green   = s[1][7:0];
      r.out_blue    = s[2][7:0];
      r.out_row     = row[15:0];
      r.out_col     = col[9:0];
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic void predict_blur(req_type px_in);
      int unsigned w, h, x, y, rt, rb, ca, cb, above, above2;
      int unsigned px [3];
      rsp_type outs [$];
      w = (cfg_width == 0) ? 1 : (cfg_width > ROW_DEPTH ? ROW_DEPTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (cur_col >= w) cur_col = 0;
      if (cur_row >= h) cur_row = 0;
      x = cur_col;
      y = cur_row;
      px[0] = px_in.pixel_red;
      px[1] = px_in.pixel_green;
      px[2] = px_in.pixel_blue;
      if (x == 0)
         for (int p = 0; p < 3; p++)
            for (int c = 0; c < 3; c++) begin
               sum3[p][c] = 0;
               sum2[p][c] = 0;
            end
      for (int p = 0; p < 2; p++)
         for (int c = 0; c < 3; c++) begin
            sum3[p][c] = sum3[p+1][c];
            sum2[p][c] = sum2[p+1][c];
         end
      for (int c = 0; c < 3; c++) begin
         above  = (y >= 1) ? above_row[x][c] : 0;
         above2 = (y >= 2) ? older_row[x][c] : 0;
         sum2[2][c] = px[c] + above;
         sum3[2][c] = px[c] + above + above2;
         older_row[x][c] = above_row[x][c];
         above_row[x][c] = px[c][7:0];
      end
      rt = (y >= 2) ? 3 : 2;
      rb = (y >= 1) ? 2 : 1;
      ca = (x >= 2) ? 3 : 2;
      cb = (x >= 1) ? 2 : 1;
      if (y >= 1) begin
         if (x >= 1) outs.push_back(blur_pixel(1, 0, rt * ca, y - 1, x - 1));
         if (x == w - 1) outs.push_back(blur_pixel(1, 1, rt * cb, y - 1, x));
      end
      if (y == h - 1) begin
         if (x >= 1) outs.push_back(blur_pixel(0, 0, rb * ca, y, x - 1));
         if (x == w - 1) outs.push_back(blur_pixel(0, 1, rb * cb, y, x));
      end
      if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
      foreach (outs[i]) blurred_q.push_back(outs[i]);
      cur_col = x + 1;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row = y + 1;
         if (cur_row >= h) cur_row = 0;
      end
   endfunction

   // hold the request until accepted; the caller drops push after the last one
   task automatic send_pixel(req_type px);
      while (!tx_no_idle && $urandom_range(99) < 15) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_blur(px);
   endtask

   function automatic req_type rand_pixel();
      req_type p;
      p = req_type'(24'($urandom));
      return p;
   endfunction

   task automatic drain_results();
      while (blurred_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) cfg_width = value[10:0];
      else cfg_height = value;
      restart_frame();
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      drain_results();
      write_csr(CSR_FRAME_WIDTH, w[15:0]);
      write_csr(CSR_FRAME_HEIGHT, h[15:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(int unsigned w, int unsigned h, bit extremes);
      req_type p;
      for (int i = 0; i < w * h; i++) begin
         if (extremes) p = (i % 2) ? '1 : '0;
         else p = rand_pixel();
         send_pixel(p);
      end
      req_push <= 1'b0;
   endtask

   // directed: extreme pixel values, corners, edges and degenerate frames
   task automatic test_directed();
      set_frame(3, 3);
      send_frame(3, 3, 1);
      set_frame(1, 1);
      send_frame(1, 1, 1);
      set_frame(4, 1);
      send_frame(4, 1, 0);
      set_frame(1, 4);
      send_frame(1, 4, 0);
   endtask

   // out-of-range settings: zero width and height act as one, wide width clamps
   task automatic test_range_limits();
      set_frame(0, 0);
      send_frame(1, 2, 0);
      set_frame(2047, 1);
      send_frame(6, 1, 0);
      set_frame(1024, 65535);
      send_frame(3, 1, 0);
   endtask

   // random small frames, each sent whole
   task automatic test_random_frames();
      int unsigned w, h;
      tx_no_idle = 1'b1;
      rx_no_idle = 1'b1;
      set_frame(5, 4);
      send_frame(5, 4, 0);
      tx_no_idle = 1'b0;
      rx_no_idle = 1'b0;
      for (int f = 0; f < 4; f++) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 5);
         set_frame(w, h);
         send_frame(w, h, 0);
      end
   endtask

   // stall the result side so the block backs up into its input
   task automatic test_backpressure();
      set_frame(6, 4);
      rx_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            rx_hold = 1'b0;
         end
         send_frame(6, 4, 0);
      join
      drain_results();
      set_frame(1024, 768);
      send_frame(4, 1, 0);
   endtask

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_data   = '0;
      fail_count = 0;
      rx_hold    = 1'b0;
      rx_no_idle = 1'b0;
      tx_no_idle = 1'b0;
      for (int i = 0; i < ROW_DEPTH; i++)
         for (int c = 0; c < 3; c++) begin
            above_row[i][c] = '0;
            older_row[i][c] = '0;
         end
      cfg_width  = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_range_limits();
      test_random_frames();
      test_backpressure();
      drain_results();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !rx_hold && (rx_no_idle || $urandom_range(99) >= 15);
   end

   // compare each popped result against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (blurred_q.size() == 0) begin
            $error("unexpected result row %0d col %0d", rsp_data.out_row, rsp_data.out_col);
            fail_count++;
         end else begin
            exp_r = blurred_q.pop_front();
            if (rsp_data.out_red !== exp_r.out_red) begin
               $error("out_red exp %0d got %0d", exp_r.out_red, rsp_data.out_red);
               fail_count++;
            end
            if (rsp_data.out_green !== exp_r.out_green) begin
               $error("out_green exp %0d got %0d", exp_r.out_green, rsp_data.out_green);
               fail_count++;
            end
            if (rsp_data.out_blue !== exp_r.out_blue) begin
               $error("out_blue exp %0d got %0d", exp_r.out_blue, rsp_data.out_blue);
               fail_count++;
            end
            if (rsp_data.out_row !== exp_r.out_row) begin
               $error("out_row exp %0d got %0d", exp_r.out_row, rsp_data.out_row);
               fail_count++;
            end
            if (rsp_data.out_col !== exp_r.out_col) begin
               $error("out_col exp %0d got %0d", exp_r.out_col, rsp_data.out_col);
               fail_count++;
            end
            if (rsp_data.last_of_run !== exp_r.last_of_run) begin
               $error("last_of_run exp %0d got %0d", exp_r.last_of_run,
                      rsp_data.last_of_run);
               fail_count++;
            end
         end
      end
   end

endmodule

// ===== sim.f =====
src/bbl_pkg.sv
src/bbl_ram.sv
src/bbl_fifo.sv
src/bbl_front.sv
src/bbl_back.sv
src/box_blur_3x3_stream_core.sv
src/bbl_checker.sv
test/box_blur_3x3_stream_core_tb.sv
